[rtl/ising_chain_magnetization_sum_top_macros.svh]
// Assertion macros for the magnetisation block
`ifndef ISING_CHAIN_MAGNETIZATION_SUM_TOP_MACROS_SVH
`define ISING_CHAIN_MAGNETIZATION_SUM_TOP_MACROS_SVH
// property a implies property b on the next edge
`define ICM_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("icm: handshake check failed");
// combinational relation held at every edge
`define ICM_ASSERT_NOW(label, a) \
  label: assert property (@(posedge clk) disable iff (rst) (a)) \
    else $error("icm: check failed");
`endif

[rtl/icm_pkg.sv]
// ---------------------------------------------------------------------------
// icm_pkg
// Types and constants shared by the magnetisation block.
// ---------------------------------------------------------------------------
package icm_pkg;
  localparam int FieldW = 24;
  localparam int MagW   = 24;
  localparam int CfgW   = 11;
  localparam int Steps  = 30;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [23:0] MagOne = 24'd4194304;

  // arctangent table, units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    begin
      unique case (i)
        5'd0:  t = 32'h20000000; 5'd1:  t = 32'h12E4051E;
        5'd2:  t = 32'h09FB385B; 5'd3:  t = 32'h051111D4;
        5'd4:  t = 32'h028B0D43; 5'd5:  t = 32'h0145D7E1;
        5'd6:  t = 32'h00A2F61E; 5'd7:  t = 32'h00517C55;
        5'd8:  t = 32'h0028BE53; 5'd9:  t = 32'h00145F2F;
        5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
        5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
        5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
        5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
        5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
        5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
        5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
        5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014;
        5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
        5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
        default: t = 32'h0;
      endcase
      return t;
    end
  endfunction
endpackage

[rtl/icm_if.sv]
// ---------------------------------------------------------------------------
// icm_if
// Valid/ready channel carrying one word of W bits.
// ---------------------------------------------------------------------------
interface icm_if #(parameter int W = 24) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/ising_chain_magnetization_sum_top.sv]
// ---------------------------------------------------------------------------
// ising_chain_magnetization_sum_top
// Per word: n_even terms, where n_even is 2*trunc(n/2), then a rounding divide
// at the end; when n is 0 the word is zero and no term is run. Each term is
// two passes of the shared 64-bit divider (phase and term), 30 CORDIC steps,
// the root steps and sequencing; the term divide is skipped if its root is zero.
// in is not ready while a word is at work, so the next word is taken only
// after the output handshake.
// Reset (rst, synchronous): controller idle, site_count back to 64.
// ---------------------------------------------------------------------------
`include "ising_chain_magnetization_sum_top_macros.svh"
module ising_chain_magnetization_sum_top #(
  parameter int MAX_SITES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [icm_pkg::CfgW-1:0] cfg_wdata,
  icm_if.sink               in_ch,
  icm_if.source             out_ch
);
  import icm_pkg::*;

  localparam int NW = $clog2(MAX_SITES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_NEXT, S_PHASE, S_CORDIC, S_DIFF, S_SQRT, S_TERM, S_ACC,
    S_FINAL, S_ROUND, S_OUT
  } state_t;

  state_t state;
  logic [CfgW-1:0] site_count;
  logic [NW-1:0] n;
  logic [NW-1:0] half;
  logic [NW:0] a;
  logic [NW-1:0] cnt;
  logic signed [FieldW-1:0] h;
  logic [1:0] q;
  logic signed [33:0] cx, cy;
  logic signed [33:0] z;
  logic [4:0] step;
  logic signed [33:0] xd;
  logic [63:0] sq_v, sq_res, sq_bit;
  logic signed [47:0] sum;
  logic neg;
  logic [MagW-1:0] mag;

  // shared divider
  logic         div_start;
  logic [63:0]  div_num, div_den, div_quo;
  logic         div_done;

  icm_divu #(.W(64)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // clamp of the register to the supported count
  logic [NW-1:0] n_clamp;
  always_comb begin
    if ({1'b0, site_count} > (CfgW + 1)'(MAX_SITES) && CfgW >= NW)
      n_clamp = NW'(MAX_SITES);
    else
      n_clamp = NW'(site_count);
  end

  // CORDIC step terms
  logic signed [33:0] sdx, sdy, cos_v, sin_v;
  logic [31:0] at;
  assign sdx = cy >>> step;
  assign sdy = cx >>> step;
  assign at  = atan_turn(step);
  always_comb begin
    unique case (q)
      2'd0: begin cos_v = cx;  sin_v = cy;  end
      2'd1: begin cos_v = -cy; sin_v = cx;  end
      2'd2: begin cos_v = -cx; sin_v = -cy; end
      default: begin cos_v = cy; sin_v = -cx; end
    endcase
  end

  // difference terms in Q28
  logic signed [35:0] xq, yq;
  logic [33:0] ax, ay;
  assign xq = ($signed({{2{h[FieldW-1]}}, h, 10'd0}) - 36'(cos_v)) >>> 2;
  assign yq = 36'(sin_v) >>> 2;
  assign ax = xq[35] ? 34'(-xq) : 34'(xq);
  assign ay = yq[35] ? 34'(-yq) : 34'(yq);

  // square root bit step
  logic [63:0] sq_try;
  assign sq_try = sq_res + sq_bit;

  logic [31:0] ph32;
  assign ph32 = div_quo[31:0];

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = neg ? MagW'(-mag) : mag;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) site_count <= CfgW'(64);
    else if (cfg_we) site_count <= cfg_wdata;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          h    <= in_ch.data;
          n    <= n_clamp;
          half <= n_clamp >> 1;
          cnt  <= '0;
          sum  <= '0;
          // first numerator 2m+1 for momentum index m = -trunc(n/2), folded into 0 .. 2n-1
          a    <= {n_clamp, 1'b0} + (NW+1)'(1) - (NW+1)'({n_clamp[NW-1:1], 1'b0});
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (cnt == {half, 1'b0} >> 0 || n == '0) begin
            state <= S_FINAL;
          end else begin
            div_num <= 64'(a) << 31;
            div_den <= 64'(n);
            div_start <= 1'b1;
            state <= S_PHASE;
          end
        end
        S_PHASE: if (div_done) begin
          q    <= 2'((ph32 + 32'h20000000) >> 30);
          z    <= 34'(signed'(ph32 - {2'((ph32 + 32'h20000000) >> 30), 30'd0}));
          cx   <= CordicGain;
          cy   <= '0;
          step <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!z[33]) begin
            cx <= cx - sdx; cy <= cy + sdy; z <= z - 34'(at);
          end else begin
            cx <= cx + sdx; cy <= cy - sdy; z <= z + 34'(at);
          end
          step <= step + 1'b1;
          if (step == 5'(Steps - 1)) state <= S_DIFF;
        end
        S_DIFF: begin
          xd     <= 34'(xq);
          sq_v   <= 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
          div_num <= 64'(ax) << 30;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_bit == '0) begin
            div_den <= sq_res;
            div_start <= (sq_res != '0);
            state <= (sq_res != '0) ? S_TERM : S_ACC;
          end else begin
            if (sq_v >= sq_try) begin
              sq_v   <= sq_v - sq_try;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_TERM: if (div_done) begin
          sum <= xd[33] ? sum - 48'(div_quo) : sum + 48'(div_quo);
          state <= S_ACC;
        end
        S_ACC: begin
          cnt <= cnt + 1'b1;
          a   <= (a + 2'd2 >= (NW+1)'({n, 1'b0})) ? a + 2'd2 - (NW+1)'({n, 1'b0})
                                                : a + 2'd2;
          state <= S_NEXT;
        end
        S_FINAL: begin
          // sum is still zero when there are no sites
          neg <= sum[47];
          if (n == '0) begin
            mag <= '0; state <= S_OUT;
          end else begin
            div_num <= 64'(sum[47] ? -sum : sum) + (64'(n) << 7);
            div_den <= 64'(n) << 8;
            div_start <= 1'b1;
            state <= S_ROUND;
          end
        end
        S_ROUND: if (div_done) begin
          mag <= (div_quo > 64'(MagOne)) ? MagOne : MagW'(div_quo);
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `ICM_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
  `ICM_ASSERT_NOW(a_mag_range, !out_ch.valid || mag <= MagOne)
  `ICM_ASSERT_NOW(a_excl, !(in_ch.ready && out_ch.valid))
endmodule

[rtl/icm_divu.sv]
// ---------------------------------------------------------------------------
// icm_divu
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module icm_divu #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] rem;
  logic [W-1:0] q;
  logic [W-1:0] d;
  logic [CW-1:0] cnt;
  logic busy;
  logic [W:0] trial;

  // shift remainder in one numerator bit and try a subtract
  assign trial = {rem, q[W-1]} - {1'b0, d};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        q    <= num;
        d    <= den;
        cnt  <= CW'(W);
      end else if (busy) begin
        if (trial[W]) begin
          rem <= {rem[W-2:0], q[W-1]};
          q   <= {q[W-2:0], 1'b0};
        end else begin
          rem <= trial[W-1:0];
          q   <= {q[W-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[dv/ising_chain_magnetization_sum_top_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ising_chain_magnetization_sum_top_checker
// Watches the field and magnetisation channels and the site count write port.
// It predicts each magnetisation word with its own fixed point model and
// compares the words in order.
// ---------------------------------------------------------------------------
module ising_chain_magnetization_sum_top_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [icm_pkg::CfgW-1:0]   cfg_wdata,
  icm_if                             in_ch,
  icm_if                             out_ch,
  output int                         mismatches,
  output int                         outstanding
);
  import icm_pkg::*;

  localparam int  SiteLimit = 1024;
  localparam longint Gain   = 652032874;
  localparam longint MagSat = 4194304;

  // arctangents in units of 2^-32 turn
  localparam longint AngleStep [30] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
    'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
    'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
    'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
    'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
    'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
  };

  logic [CfgW-1:0] site_count;
  logic [MagW-1:0] mag_queue [$];

  // exact floor square root
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // rotation CORDIC, phase in 2^-32 turn, cos/sin in Q30
  task automatic rotate_phase(input logic [31:0] phase, output longint c,
                              output longint s);
    logic [1:0]  quad;
    logic [31:0] resid;
    longint      x, y, z, dx, dy;
    quad  = 2'((phase + 32'h20000000) >> 30);
    resid = phase - (32'(quad) << 30);
    z = longint'($signed(resid));
    x = Gain;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - AngleStep[i];
      end else begin
        x = x + dx; y = y - dy; z = z + AngleStep[i];
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // averaged sigma_z over the half-integer momentum grid
  task automatic predict_magnetization(input logic [FieldW-1:0] field,
                                       input logic [CfgW-1:0] sites,
                                       output logic [MagW-1:0] mag_word);
    longint      h, n, half, a, c, s, x, y, t, sum, res;
    logic [63:0] ax, ay, r, mag, divisor, num;
    logic [31:0] phase;
    h = longint'($signed(field));
    n = longint'(sites);
    if (n > SiteLimit) n = SiteLimit;
    sum = 0;
    res = 0;
    if (n > 0) begin
      half = n / 2;
      for (longint m = -half; m <= half - 1; m++) begin
        a = 2 * m + 1;
        if (a < 0) a = a + 2 * n;
        num   = 64'(a) << 31;
        phase = 32'(num / 64'(n));
        rotate_phase(phase, c, s);
        x  = (h * 1024 - c) >>> 2;
        y  = s >>> 2;
        ax = 64'(x < 0 ? -x : x);
        ay = 64'(y < 0 ? -y : y);
        r  = floor_root(ax * ax + ay * ay);
        if (r == 0) begin
          t = 0;
        end else begin
          t = longint'((ax << 30) / r);
          if (x < 0) t = -t;
        end
        sum = sum + t;
      end
      mag     = 64'(sum < 0 ? -sum : sum);
      divisor = 64'(n) << 8;
      mag     = (mag + (divisor >> 1)) / divisor;
      if (mag > 64'(MagSat)) mag = 64'(MagSat);
      res = sum < 0 ? -longint'(mag) : longint'(mag);
    end
    mag_word = MagW'(res);
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // follow config writes, predict accepted fields, check returned words
  always @(posedge clk) begin
    logic [MagW-1:0] want;
    if (rst) begin
      site_count = 11'd64;
      mag_queue.delete();
      mismatches = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_magnetization(in_ch.data, site_count, want);
        mag_queue.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (mag_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d", $signed(out_ch.data)));
        end else begin
          want = mag_queue.pop_front();
          if (out_ch.data !== want)
            report_mismatch($sformatf("magnetization %0d, want %0d",
                                      $signed(out_ch.data), $signed(want)));
        end
      end
      if (cfg_we) site_count = cfg_wdata;
    end
    outstanding = mag_queue.size();
  end
endmodule

[dv/ising_chain_magnetization_sum_top_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ising_chain_magnetization_sum_top_test
// Drives transverse field words through the magnetisation block over a range
// of site counts, with random gaps and stalls, and reports the verdict.
// ---------------------------------------------------------------------------
module ising_chain_magnetization_sum_top_test;
  import icm_pkg::*;

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_wdata;
  int              mismatches;
  int              outstanding;
  bit              gaps_on;
  bit              hold_req;

  icm_if #(.W(FieldW)) in_ch (clk);
  icm_if #(.W(MagW))   out_ch (clk);

  ising_chain_magnetization_sum_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ising_chain_magnetization_sum_top_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // offer one field word, with an optional random gap first
  task automatic send_field(input logic [FieldW-1:0] field);
    while (gaps_on && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= field;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait for every outstanding word
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_sites(input logic [CfgW-1:0] sites);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= sites;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // field near the critical region half the time, else anywhere
  function automatic logic [FieldW-1:0] random_field;
    if ($urandom_range(1) == 0) return FieldW'($urandom);
    return FieldW'(int'($urandom_range(6 << 20)) - (3 << 20));
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= !(gaps_on && $urandom_range(99) < 20);
    end
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [FieldW-1:0] edge_fields [6];
    edge_fields = '{24'h000000, 24'h800000, 24'h7FFFFF, 24'h100000,
                    24'hF00000, 24'h000001};
    gaps_on      = 1'b1;
    hold_req     = 1'b0;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default of 64 sites: field extremes and the critical points
    foreach (edge_fields[i]) send_field(edge_fields[i]);

    // zero sites, single site, above the cap, the cap and two sites
    write_sites(11'd0);
    send_field(24'h7FFFFF);
    send_field(24'h800000);
    write_sites(11'd1);
    send_field(24'h100000);
    send_field(24'h800000);
    write_sites(11'd2047);
    send_field(24'h080000);
    write_sites(11'd1024);
    send_field(24'hF00000);
    write_sites(11'd2);
    send_field(24'h7FFFFF);
    send_field(24'h000000);

    // random phases with small site counts
    for (int ph = 0; ph < 7; ph++) begin
      write_sites(CfgW'($urandom_range(12, 2)));
      gaps_on = (ph != 2);
      if (ph == 4) hold_req = 1'b1;
      for (int k = 0; k < 20; k++) send_field(random_field());
    end
    gaps_on = 1'b1;

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[ising_chain_magnetization_sum_top.f]
+incdir+rtl
rtl/icm_pkg.sv
rtl/icm_if.sv
rtl/icm_divu.sv
rtl/ising_chain_magnetization_sum_top.sv
dv/ising_chain_magnetization_sum_top_checker.sv
dv/ising_chain_magnetization_sum_top_test.sv
